>>> src/ramct_pkg.sv
package ramct_pkg;

    // Table geometry. The block size is a power of two so a slot index splits
    // into a block number and an offset by bit selection.
    localparam int SLOTS      = 1024;
    localparam int OFF_W      = 5;
    localparam int BLOCK_SIZE = 1 << OFF_W;
    localparam int NUM_BLOCKS = (SLOTS + BLOCK_SIZE - 1) / BLOCK_SIZE;
    localparam int BLK_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int MEM_DEPTH  = NUM_BLOCKS * BLOCK_SIZE;
    localparam int ADDR_W     = BLK_W + OFF_W;

    // Field widths of the stream items.
    localparam int SLOT_W      = 10;
    localparam int VALUE_W     = 31;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 16;

    typedef logic [BLK_W-1:0]      t_blk;
    typedef logic [OFF_W-1:0]      t_off;
    typedef logic [VALUE_W-1:0]    t_value;
    typedef logic [SLOT_W-1:0]     t_slot;
    typedef logic [BLOCK_SIZE-1:0] t_row;

    localparam t_blk LAST_BLK = t_blk'(NUM_BLOCKS - 1);
    localparam t_off OFF_MAX  = t_off'(BLOCK_SIZE - 1);

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LD_RD,
        S_LD_WR,
        S_SUM,
        S_ROW_RD,
        S_ROW_GET,
        S_FIND,
        S_CLAIM,
        S_REB,
        S_OUT
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic clr_step;
        logic accept;
        logic ld_rd;
        logic ld_wr;
        logic sum_step;
        logic row_rd;
        logic row_get;
        logic scan_up_init;
        logic scan_down_init;
        logic scan_issue;
        logic find_hit;
        logic claim;
        logic sum_write;
        logic out_load;
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic in_query;
        logic in_ld_ok;
        logic clr_last;
        logic sum_hit;
        logic sum_last;
        logic find_hit;
        logic find_end;
        logic reb_done;
        logic is_query;
        logic out_free;
    } t_dp_sts;

endpackage

>>> src/ramct_ctrl.sv
module ramct_ctrl
    import ramct_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.in_query) begin
                        n_state = S_SUM;
                    end else if (i_sts.in_ld_ok) begin
                        n_state = S_LD_RD;
                    end
                end
            end
            S_LD_RD: begin
                o_cmd.ld_rd = 1'b1;
                n_state     = S_LD_WR;
            end
            S_LD_WR: begin
                o_cmd.ld_wr        = 1'b1;
                o_cmd.scan_up_init = 1'b1;
                n_state            = S_REB;
            end
            S_SUM: begin
                o_cmd.sum_step = 1'b1;
                if (i_sts.sum_hit) begin
                    n_state = S_ROW_RD;
                end else if (i_sts.sum_last) begin
                    n_state = S_OUT;
                end
            end
            S_ROW_RD: begin
                o_cmd.row_rd = 1'b1;
                n_state      = S_ROW_GET;
            end
            S_ROW_GET: begin
                o_cmd.row_get        = 1'b1;
                o_cmd.scan_down_init = 1'b1;
                n_state              = S_FIND;
            end
            S_FIND: begin
                o_cmd.scan_issue = 1'b1;
                if (i_sts.find_hit) begin
                    o_cmd.find_hit = 1'b1;
                    n_state        = S_CLAIM;
                end else if (i_sts.find_end) begin
                    n_state = S_OUT;
                end
            end
            S_CLAIM: begin
                o_cmd.claim        = 1'b1;
                o_cmd.scan_up_init = 1'b1;
                n_state            = S_REB;
            end
            S_REB: begin
                o_cmd.scan_issue = 1'b1;
                if (i_sts.reb_done) begin
                    o_cmd.sum_write = 1'b1;
                    n_state         = i_sts.is_query ? S_OUT : S_IDLE;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> src/ramct_dp.sv
module ramct_dp
    import ramct_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  logic                   i_s_tuser,
    input  logic                   i_m_tready,
    output logic                   o_m_tvalid,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    output logic                   o_m_tuser,
    input  t_dp_cmd                i_cmd,
    output t_dp_sts                o_sts
);

    // Storage: slot values, alive bits by block row, block summaries.
    t_value                r_vmem [MEM_DEPTH];
    t_row                  r_amem [NUM_BLOCKS];
    t_value                r_bmin [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0] r_bany;

    t_slot  in_slot;
    t_value in_value;

    logic   r_is_query;
    t_value r_thr;
    t_blk   r_blk;
    t_off   r_off;
    t_blk   r_sblk;
    t_blk   r_clr_cnt;

    t_row   r_row_rd;
    t_row   r_row;
    t_row   n_row_wdata;
    t_blk   n_row_waddr;
    logic   n_row_we;

    t_off   r_cnt;
    logic   r_dir_up;
    logic   r_iss_done;
    logic   r_dv;
    t_off   r_doff;
    t_value r_vdata;
    logic   r_acc_any;
    t_value r_acc_min;
    logic   n_acc_any;
    t_value n_acc_min;
    logic   issue;
    logic   slot_hit;
    logic   take;

    logic   r_res_found;
    t_slot  r_res_slot;
    logic   r_out_valid;
    logic   r_out_found;
    t_slot  r_out_slot;

    assign in_slot  = i_s_tdata[SLOT_W-1:0];
    assign in_value = i_s_tdata[SLOT_W+VALUE_W-1:SLOT_W];

    assign issue    = i_cmd.scan_issue && !r_iss_done;
    assign take     = r_dv && r_row[r_doff];
    assign slot_hit = take && (r_vdata <= r_thr);

    always_comb begin
        n_acc_any = r_acc_any;
        n_acc_min = r_acc_min;
        if (take && (!r_acc_any || r_vdata < r_acc_min)) begin
            n_acc_any = 1'b1;
            n_acc_min = r_vdata;
        end
    end

    always_comb begin
        n_row_we    = 1'b0;
        n_row_waddr = r_blk;
        n_row_wdata = '0;
        priority if (i_cmd.clr_step) begin
            n_row_we    = 1'b1;
            n_row_waddr = r_clr_cnt;
        end else if (i_cmd.ld_wr) begin
            n_row_we    = 1'b1;
            n_row_wdata = r_row_rd | (t_row'(1) << r_off);
        end else if (i_cmd.claim) begin
            n_row_we    = 1'b1;
            n_row_wdata = r_row & ~(t_row'(1) << r_off);
        end else begin
            n_row_we = 1'b0;
        end
    end

    always_comb begin
        o_sts.in_query = (i_s_tuser == CMD_QUERY);
        o_sts.in_ld_ok = (32'(in_slot) < 32'(SLOTS));
        o_sts.clr_last = (r_clr_cnt == LAST_BLK);
        o_sts.sum_hit  = r_bany[r_sblk] && (r_bmin[r_sblk] <= r_thr);
        o_sts.sum_last = (r_sblk == '0);
        o_sts.find_hit = slot_hit;
        o_sts.find_end = r_dv && !r_dir_up && (r_doff == '0) && !slot_hit;
        o_sts.reb_done = r_dv && r_dir_up && (r_doff == OFF_MAX);
        o_sts.is_query = r_is_query;
        o_sts.out_free = !r_out_valid || i_m_tready;
    end

    // Memories.
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_rd) begin
            r_vmem[{r_blk, r_off}] <= r_thr;
        end
        if (issue) begin
            r_vdata <= r_vmem[{r_blk, r_cnt}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_row_we) begin
            r_amem[n_row_waddr] <= n_row_wdata;
        end
        if (i_cmd.ld_rd || i_cmd.row_rd) begin
            r_row_rd <= r_amem[r_blk];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum_write) begin
            r_bmin[r_blk] <= n_acc_min;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bany      <= '0;
            r_clr_cnt   <= '0;
            r_dv        <= 1'b0;
            r_iss_done  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (i_cmd.sum_write) begin
                r_bany[r_blk] <= n_acc_any;
            end
            if (i_cmd.scan_up_init || i_cmd.scan_down_init) begin
                r_dv       <= 1'b0;
                r_iss_done <= 1'b0;
            end else begin
                r_dv <= issue;
                if (issue) begin
                    r_iss_done <= r_dir_up ? (r_cnt == OFF_MAX) : (r_cnt == '0);
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_is_query  <= (i_s_tuser == CMD_QUERY);
            r_thr       <= in_value;
            r_blk       <= BLK_W'(32'(in_slot) >> OFF_W);
            r_off       <= OFF_W'(in_slot);
            r_sblk      <= LAST_BLK;
            r_res_found <= 1'b0;
            r_res_slot  <= '0;
        end
        if (i_cmd.sum_step) begin
            if (o_sts.sum_hit) begin
                r_blk <= r_sblk;
            end
            r_sblk <= r_sblk - 1'b1;
        end
        if (i_cmd.ld_wr || i_cmd.claim) begin
            r_row <= n_row_wdata;
        end else if (i_cmd.row_get) begin
            r_row <= r_row_rd;
        end
        if (i_cmd.scan_up_init) begin
            r_cnt     <= '0;
            r_dir_up  <= 1'b1;
            r_acc_any <= 1'b0;
            r_acc_min <= '0;
        end else if (i_cmd.scan_down_init) begin
            r_cnt     <= OFF_MAX;
            r_dir_up  <= 1'b0;
            r_acc_any <= 1'b0;
            r_acc_min <= '0;
        end else begin
            if (issue) begin
                r_cnt <= r_dir_up ? (r_cnt + 1'b1) : (r_cnt - 1'b1);
            end
            r_acc_any <= n_acc_any;
            r_acc_min <= n_acc_min;
        end
        if (issue) begin
            r_doff <= r_cnt;
        end
        if (i_cmd.find_hit) begin
            r_off       <= r_doff;
            r_res_found <= 1'b1;
            r_res_slot  <= SLOT_W'({r_blk, r_doff});
        end
        if (i_cmd.out_load) begin
            r_out_found <= r_res_found;
            r_out_slot  <= r_res_slot;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_found;
    assign o_m_tdata  = {{(OUT_TDATA_W - SLOT_W){1'b0}}, r_out_slot};

endmodule

>>> src/rightmost_at_most_claim_table_top.sv
// Load transaction: value write, alive-row update, block rescan.
// Query transaction: summary walk, slot scan and rescan of the claimed block, one entry a cycle.
// One transaction is worked at a time; a new one is taken while a result waits at the output.
// Reset (synchronous, active low) starts a clearing pass that zeroes the alive rows; no
// transaction is accepted until it completes.
module rightmost_at_most_claim_table_top
    import ramct_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // slot [9:0], value [40:10], zero pad [47:41]
    input  logic                   i_s_tuser,   // cmd: 0 load a slot, 1 query a threshold
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,   // claimed_slot [9:0], zero pad [15:10]
    output logic                   o_m_tuser    // found
);

    // The controller sequences every transaction; the datapath holds the slot
    // value memory, the alive bits stored as one row per block, the block
    // summaries (any slot alive, minimum alive value) and the output register.
    t_dp_cmd cmd;
    t_dp_sts sts;

    // A query walks the summaries from the highest block down and stops at the
    // first block whose minimum is at or below the threshold. That block's row
    // of alive bits is read, then its slots are scanned from the top offset
    // down through the value memory, which has a registered read.
    // The first alive slot at or below the threshold is claimed: its alive bit
    // is cleared and the block is rescanned to rebuild its minimum. A load
    // writes the value, sets the alive bit and rescans the block the same way.
    ramct_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ramct_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_cmd      (cmd),
        .o_sts      (sts)
    );

endmodule

>>> src/ramct_checker.sv
module ramct_checker
    import ramct_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_tvalid,
    input logic                   o_s_tready,
    input logic [IN_TDATA_W-1:0]  i_s_tdata,
    input logic                   i_s_tuser,
    input logic                   o_m_tvalid,
    input logic                   i_m_tready,
    input logic [OUT_TDATA_W-1:0] o_m_tdata,
    input logic                   o_m_tuser
);

    // A result that is not taken holds still.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result changed while stalled");

    // A not-found result carries a zero slot.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata == '0)
        else $error("not-found result with nonzero slot");

    // Reset starts the clearing pass, so nothing is accepted right after it.
    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_tready && !o_m_tvalid)
        else $error("ready or result right after reset");

    // A query keeps the block busy for at least the next cycle.
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tuser == CMD_QUERY |=> !o_s_tready)
        else $error("ready right after a query");

endmodule

bind rightmost_at_most_claim_table_top ramct_checker u_ramct_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
